/* hw/rtl/cft_pkg.sv */
`timescale 1ns / 1ps

package cft_pkg;

  localparam int unsigned DefMaxColumns = 1023;
  localparam int unsigned DefMaxRows    = 65535;

  localparam logic [15:0] CH_CR = 16'd13;
  localparam logic [15:0] CH_LF = 16'd10;

  localparam logic [15:0] RST_DELIMITER = 16'd44;
  localparam logic [15:0] RST_QUOTE     = 16'd34;

  localparam logic [1:0] CFG_DELIMITER  = 2'd0;
  localparam logic [1:0] CFG_QUOTE      = 2'd1;
  localparam logic [1:0] CFG_IGNORE_DUP = 2'd2;
  localparam logic [1:0] CFG_START_LINE = 2'd3;

  typedef enum logic [2:0] {
    ST_START        = 3'd0,
    ST_QUOTED       = 3'd1,
    ST_MAYBE_END_Q  = 3'd2,
    ST_END_Q        = 3'd3,
    ST_MAYBE_NORMAL = 3'd4,
    ST_NORMAL       = 3'd5
  } parse_state_t;

  typedef enum logic [1:0] {
    RK_CHAR    = 2'd0,
    RK_COMMIT  = 2'd1,
    RK_DISCARD = 2'd2,
    RK_SUMMARY = 2'd3
  } result_kind_t;

  typedef struct packed {
    logic [15:0] delimiter_char;
    logic [15:0] quote_char;
    logic        ignore_duplicates;
    logic [15:0] start_line;
  } cfg_t;

  typedef struct packed {
    result_kind_t kind;
    logic [15:0]  ch;
    logic [15:0]  line;
    logic [9:0]   column;
    logic         last;
  } result_t;

endpackage

/* hw/rtl/cft_parser.sv */
`timescale 1ns / 1ps

module cft_parser #(
  parameter int unsigned MAX_COLUMNS = cft_pkg::DefMaxColumns,
  parameter int unsigned MAX_ROWS    = cft_pkg::DefMaxRows
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cft_pkg::cfg_t    cfg,
  input  logic             in_fire,
  input  logic             in_kind,
  input  logic [15:0]      in_char_code,
  input  logic             fifo_full,
  output cft_pkg::result_t res,
  output logic             res_push,
  output logic             sum_pend
);
  import cft_pkg::*;

  localparam int unsigned RW  = $clog2(MAX_ROWS + 1);
  localparam int unsigned CW  = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned LW  = (RW > 16) ? RW : 16;
  localparam logic [RW-1:0] ROW_MAX = RW'(MAX_ROWS);
  localparam logic [CW-1:0] COL_MAX = CW'(MAX_COLUMNS);

  parse_state_t  st_r, st_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [CW-1:0] wid_r, wid_nxt;
  logic          lwd_r, lwd_nxt;
  logic          txt_r, txt_nxt;
  logic          skip_r, skip_nxt;
  logic          pend_r, pend_nxt;
  result_t       sum_r, sum_nxt;

  logic          is_quote, is_delim, is_lf;
  logic          vis;
  logic [RW-1:0] row_inc, row_end;
  logic [CW-1:0] col_inc;
  logic [15:0]   line_cur, sum_line;
  logic          do_app, do_fin, do_col, do_row, emit_req;
  result_kind_t  emit_kind;
  logic [15:0]   emit_ch;
  result_t       sum_item;

  assign is_quote = (cfg.quote_char != 16'd0) && (in_char_code == cfg.quote_char);
  assign is_delim = (in_char_code == cfg.delimiter_char);
  assign is_lf    = (in_char_code == CH_LF);

  assign vis      = LW'(row_r) > LW'(cfg.start_line);
  assign row_inc  = (row_r < ROW_MAX) ? row_r + RW'(1) : row_r;
  assign col_inc  = (col_r < COL_MAX) ? col_r + CW'(1) : col_r;
  assign row_end  = txt_r ? row_inc : row_r;
  assign line_cur = 16'(LW'(row_r) - LW'(cfg.start_line));
  assign sum_line = (LW'(row_end) > LW'(cfg.start_line)) ?
                    16'(LW'(row_end) - LW'(cfg.start_line)) : 16'd0;

  assign sum_item = '{kind: RK_SUMMARY, ch: 16'd0, line: sum_line,
                      column: 10'(wid_r), last: 1'b1};

  assign sum_pend = pend_r;

  always_comb begin
    st_nxt    = st_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    wid_nxt   = wid_r;
    lwd_nxt   = lwd_r;
    txt_nxt   = txt_r;
    skip_nxt  = skip_r;
    pend_nxt  = pend_r;
    sum_nxt   = sum_r;
    do_app    = 1'b0;
    do_fin    = 1'b0;
    do_col    = 1'b0;
    do_row    = 1'b0;
    emit_req  = 1'b0;
    emit_kind = RK_CHAR;
    emit_ch   = 16'd0;
    res       = '{kind: RK_CHAR, ch: 16'd0, line: line_cur,
                  column: 10'(col_r), last: 1'b1};
    res_push  = 1'b0;

    if (pend_r) begin
      res      = sum_r;
      res_push = !fifo_full;
      pend_nxt = fifo_full;
    end else if (in_fire && in_kind) begin
      if (txt_r && vis) begin
        res.kind = RK_COMMIT;
        res.last = 1'b0;
        res_push = 1'b1;
        pend_nxt = 1'b1;
        sum_nxt  = sum_item;
      end else begin
        res      = sum_item;
        res_push = 1'b1;
      end
      st_nxt   = ST_START;
      row_nxt  = RW'(1);
      col_nxt  = CW'(1);
      wid_nxt  = '0;
      lwd_nxt  = 1'b0;
      txt_nxt  = 1'b0;
      skip_nxt = 1'b0;
    end else if (in_fire && !skip_r && in_char_code == CH_CR) begin
      skip_nxt = 1'b1;
    end else if (in_fire) begin
      skip_nxt = 1'b0;
      unique case (st_r)
        ST_QUOTED: begin
          if (is_quote) st_nxt = ST_MAYBE_END_Q;
          else do_app = 1'b1;
        end
        ST_MAYBE_END_Q: begin
          if (is_quote) begin
            do_app = 1'b1;
            st_nxt = ST_QUOTED;
          end else if (is_delim || is_lf) begin
            do_fin = 1'b1;
          end else begin
            st_nxt = ST_END_Q;
          end
        end
        ST_END_Q: begin
          if (is_delim || is_lf) do_fin = 1'b1;
        end
        ST_MAYBE_NORMAL, ST_NORMAL: begin
          if (st_r == ST_MAYBE_NORMAL && is_quote) begin
            emit_req  = 1'b1;
            emit_kind = RK_DISCARD;
            txt_nxt   = 1'b0;
            st_nxt    = ST_QUOTED;
          end else if (is_delim || is_lf) begin
            do_fin = 1'b1;
          end else begin
            do_app = 1'b1;
          end
        end
        default: begin
          if (is_quote) begin
            st_nxt = ST_QUOTED;
          end else if (is_delim) begin
            do_col = 1'b1;
            st_nxt = ST_START;
          end else if (is_lf) begin
            do_row = 1'b1;
            st_nxt = ST_START;
          end else begin
            do_app = 1'b1;
            st_nxt = ST_MAYBE_NORMAL;
          end
        end
      endcase

      if (do_app) begin
        txt_nxt   = 1'b1;
        emit_req  = 1'b1;
        emit_kind = RK_CHAR;
        emit_ch   = in_char_code;
      end
      if (do_fin) begin
        emit_req  = 1'b1;
        emit_kind = RK_COMMIT;
        txt_nxt   = 1'b0;
        st_nxt    = ST_START;
        if (is_lf) do_row = 1'b1;
        else do_col = 1'b1;
      end
      if (do_col) begin
        if (!cfg.ignore_duplicates || !lwd_r) col_nxt = col_inc;
        lwd_nxt = 1'b1;
      end
      if (do_row) begin
        row_nxt = row_inc;
        col_nxt = CW'(1);
      end
      if (!is_delim) lwd_nxt = 1'b0;
      if (col_nxt > wid_r) wid_nxt = col_nxt;

      res.kind = emit_kind;
      res.ch   = emit_ch;
      res_push = emit_req && vis;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_START;
      row_r  <= RW'(1);
      col_r  <= CW'(1);
      wid_r  <= '0;
      lwd_r  <= 1'b0;
      txt_r  <= 1'b0;
      skip_r <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      wid_r  <= wid_nxt;
      lwd_r  <= lwd_nxt;
      txt_r  <= txt_nxt;
      skip_r <= skip_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
  end

`ifndef SYNTH
  a_wid_covers_col: assert property (@(posedge clk) disable iff (!rst_n)
    (wid_r >= col_r) || (col_r == CW'(1)))
    else $error("widest column below current column");

  a_pend_after_end_commit: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_kind && txt_r && vis && !pend_r) |=> pend_r)
    else $error("summary not held after end commit");

  a_no_input_while_pend: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> !in_fire)
    else $error("input taken while summary pending");
`endif

endmodule

/* hw/rtl/cft_out_fifo.sv */
`timescale 1ns / 1ps

module cft_out_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  cft_pkg::result_t din,
  input  logic             pop,
  output cft_pkg::result_t dout,
  output logic             dout_valid,
  output logic             full
);
  import cft_pkg::*;

  result_t    mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign dout_valid = (count_r != 2'd0);
  assign full       = (count_r == 2'd2);
  assign dout       = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && dout_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    count_nxt  = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= din;
  end

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'd2)
    else $error("fifo count out of range");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("result pushed into full fifo");

  a_hold_head: assert property (@(posedge clk) disable iff (!rst_n)
    (dout_valid && !pop) |=> (dout_valid && $stable(dout)))
    else $error("stalled result changed");
`endif

endmodule

/* hw/rtl/csv_field_tokenizer_core.sv */
`timescale 1ns / 1ps
// csv field tokenizer
// input channel: in_kind/in_char_code, one character or an end marker per transaction
// output channel: field characters, commits, discards and the end summary, each
//   with row and column; out_is_last marks the final result of an input transaction
// config channel: cfg_index/cfg_data, always ready, write only while idle
// output: a result is written into the two-entry result fifo and shows on out_* from there
// throughput: one input transaction per cycle while in_ready is high; parse state is
//   updated in the same cycle that decides the character
// an end marker that flushes a pending field makes two results and holds input off
//   while the summary goes out, longer while the fifo is full
// hidden rows and a CR not right after a skipped CR consume input but give no result
// output stall: a two-entry result fifo absorbs a stall; in_ready drops when it
//   is full and the parser holds its state
// reset: synchronous, active low; registers return to defaults, state to row 1
//   column 1, fifo empty

module csv_field_tokenizer_core #(
  parameter int unsigned MAX_COLUMNS = cft_pkg::DefMaxColumns,
  parameter int unsigned MAX_ROWS    = cft_pkg::DefMaxRows
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [15:0] in_char_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_result_kind,
  output logic [15:0] out_char,
  output logic [15:0] out_line_index,
  output logic [9:0]  out_column_index,
  output logic        out_is_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import cft_pkg::*;

  cfg_t    cfg_r, cfg_nxt;
  result_t res, head;
  logic    res_push, fifo_full, sum_pend, in_fire;

  assign cfg_ready = 1'b1;
  assign in_ready  = !fifo_full && !sum_pend;
  assign in_fire   = in_valid && in_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DELIMITER:  cfg_nxt.delimiter_char    = cfg_data;
        CFG_QUOTE:      cfg_nxt.quote_char        = cfg_data;
        CFG_IGNORE_DUP: cfg_nxt.ignore_duplicates = cfg_data[0];
        CFG_START_LINE: cfg_nxt.start_line        = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{delimiter_char: RST_DELIMITER, quote_char: RST_QUOTE,
                 ignore_duplicates: 1'b0, start_line: 16'd0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  cft_parser #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_fire     (in_fire),
    .in_kind     (in_kind),
    .in_char_code(in_char_code),
    .fifo_full   (fifo_full),
    .res         (res),
    .res_push    (res_push),
    .sum_pend    (sum_pend)
  );

  cft_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .din       (res),
    .pop       (out_ready),
    .dout      (head),
    .dout_valid(out_valid),
    .full      (fifo_full)
  );

  assign out_result_kind  = head.kind;
  assign out_char         = head.ch;
  assign out_line_index   = head.line;
  assign out_column_index = head.column;
  assign out_is_last      = head.last;

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import cft_pkg::*;

  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef struct packed {
    logic        kind;
    logic [15:0] code;
  } char_item_t;

  class csv_token_tracker;
    cfg_t         regs;
    parse_state_t state;
    int unsigned  row;
    int unsigned  column;
    int unsigned  widest;
    bit           after_delim;
    bit           has_text;
    bit           skip_cr;
    int           n_this;
    result_t      pending_tokens[$];
    int           mismatches;

    function new();
      regs.delimiter_char    = RST_DELIMITER;
      regs.quote_char        = RST_QUOTE;
      regs.ignore_duplicates = 1'b0;
      regs.start_line        = 16'd0;
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      state       = ST_START;
      row         = 1;
      column      = 1;
      widest      = 0;
      after_delim = 1'b0;
      has_text    = 1'b0;
      skip_cr     = 1'b0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        CFG_DELIMITER:  regs.delimiter_char = data;
        CFG_QUOTE:      regs.quote_char = data;
        CFG_IGNORE_DUP: regs.ignore_duplicates = data[0];
        CFG_START_LINE: regs.start_line = data;
        default: ;
      endcase
    endfunction

    function void add_token(result_kind_t kind, logic [15:0] ch, int unsigned line,
                            int unsigned col);
      result_t r;
      if (n_this != 0) pending_tokens[pending_tokens.size() - 1].last = 1'b0;
      r.kind   = kind;
      r.ch     = ch;
      r.line   = line[15:0];
      r.column = col[9:0];
      r.last   = 1'b1;
      pending_tokens.push_back(r);
      n_this++;
    endfunction

    // rows up to the start line stay silent
    function void visible_token(result_kind_t kind, logic [15:0] ch);
      if (row > regs.start_line) add_token(kind, ch, row - regs.start_line, column);
    endfunction

    function void append(logic [15:0] ch);
      has_text = 1'b1;
      visible_token(RK_CHAR, ch);
    endfunction

    function void next_row();
      if (row < DefMaxRows) row++;
    endfunction

    function void next_column();
      if (!regs.ignore_duplicates || !after_delim) begin
        if (column < DefMaxColumns) column++;
      end
      after_delim = 1'b1;
    endfunction

    function void close_field(bit is_lf);
      visible_token(RK_COMMIT, 16'd0);
      has_text = 1'b0;
      if (is_lf) begin
        next_row();
        column = 1;
      end else begin
        next_column();
      end
      state = ST_START;
    endfunction

    function void take_char(logic kind, logic [15:0] code);
      bit is_q, is_d, is_lf;
      n_this = 0;
      if (kind) begin
        if (has_text) begin
          visible_token(RK_COMMIT, 16'd0);
          next_row();
        end
        add_token(RK_SUMMARY, 16'd0, (row > regs.start_line) ? row - regs.start_line : 0,
                  widest);
        restart();
        return;
      end
      // a carriage return not right after a skipped one swallows only itself; the next character is taken as usual
      if (!skip_cr && code == CH_CR) begin
        skip_cr = 1'b1;
        return;
      end
      skip_cr = 1'b0;
      is_q  = (regs.quote_char != 16'd0) && (code == regs.quote_char);
      is_d  = (code == regs.delimiter_char);
      is_lf = (code == CH_LF);
      case (state)
        ST_QUOTED: begin
          if (is_q) state = ST_MAYBE_END_Q;
          else append(code);
        end
        ST_MAYBE_END_Q: begin
          if (is_q) begin
            append(code);
            state = ST_QUOTED;
          end else if (is_d || is_lf) begin
            close_field(is_lf);
          end else begin
            state = ST_END_Q;
          end
        end
        ST_END_Q: begin
          if (is_d || is_lf) close_field(is_lf);
        end
        ST_MAYBE_NORMAL, ST_NORMAL: begin
          if (state == ST_MAYBE_NORMAL && is_q) begin
            visible_token(RK_DISCARD, 16'd0);
            has_text = 1'b0;
            state = ST_QUOTED;
          end else if (is_d || is_lf) begin
            close_field(is_lf);
          end else begin
            append(code);
          end
        end
        default: begin
          if (is_q) begin
            state = ST_QUOTED;
          end else if (is_d) begin
            next_column();
            state = ST_START;
          end else if (is_lf) begin
            next_row();
            column = 1;
            state = ST_START;
          end else begin
            append(code);
            state = ST_MAYBE_NORMAL;
          end
        end
      endcase
      if (!is_d) after_delim = 1'b0;
      if (column > widest) widest = column;
    endfunction

    function void compare_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
        mismatches++;
      end
    endfunction

    function void match_result(logic [1:0] kind, logic [15:0] ch, logic [15:0] line,
                               logic [9:0] col, logic last);
      result_t exp_r;
      if (pending_tokens.size() == 0) begin
        $error("result with none expected: kind %0d char %0d line %0d column %0d",
               kind, ch, line, col);
        mismatches++;
        return;
      end
      exp_r = pending_tokens.pop_front();
      compare_field("result_kind", exp_r.kind, kind);
      compare_field("out_char", exp_r.ch, ch);
      compare_field("line_index", exp_r.line, line);
      compare_field("column_index", exp_r.column, col);
      compare_field("is_last", exp_r.last, last);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_kind = 1'b0;
  logic [15:0] in_char_code = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_result_kind;
  logic [15:0] out_char;
  logic [15:0] out_line_index;
  logic [9:0]  out_column_index;
  logic        out_is_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  bit          calm = 1'b0;
  bit          hold_request = 1'b0;
  logic [15:0] cur_delim = RST_DELIMITER;
  logic [15:0] cur_quote = RST_QUOTE;
  int unsigned quiet_cycles = 0;
  csv_token_tracker tracker;

  csv_field_tokenizer_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_char_code     (in_char_code),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_kind  (out_result_kind),
    .out_char         (out_char),
    .out_line_index   (out_line_index),
    .out_column_index (out_column_index),
    .out_is_last      (out_is_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) tracker.write_reg(cfg_index, cfg_data);
      if (out_valid && out_ready) begin
        tracker.match_result(out_result_kind, out_char, out_line_index, out_column_index,
                             out_is_last);
      end
      if (in_valid && in_ready) tracker.take_char(in_kind, in_char_code);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL csv_field_tokenizer_core");
      $finish;
    end
  end

  // result side back-pressure
  initial begin : result_sink
    int unsigned n;
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 14);
        repeat (n) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        n = $urandom_range(1, 40);
        repeat (n) @(posedge clk);
      end
    end
  end

  function automatic char_item_t chr(logic [15:0] code);
    char_item_t it;
    it.kind = 1'b0;
    it.code = code;
    return it;
  endfunction

  function automatic char_item_t end_item();
    char_item_t it;
    it.kind = 1'b1;
    it.code = 16'($urandom);
    return it;
  endfunction

  function automatic logic [15:0] plain_char();
    logic [15:0] c;
    do begin
      c = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(97, 122));
    end while (c == cur_delim || (cur_quote != 16'd0 && c == cur_quote) ||
               c == CH_LF || c == CH_CR);
    return c;
  endfunction

  function automatic logic [15:0] any_char();
    case ($urandom_range(0, 19))
      0, 1, 2: return cur_delim;
      3, 4:    return cur_quote;
      5, 6:    return CH_LF;
      7:       return CH_CR;
      8:       return 16'd0;
      9, 10:   return 16'($urandom);
      default: return plain_char();
    endcase
  endfunction

  function automatic void add_field(ref char_item_t items[$]);
    int unsigned style, len;
    style = $urandom_range(0, 3);
    len = $urandom_range(1, 5);
    if (style == 0) return;
    if (style == 1 || cur_quote == 16'd0) begin
      repeat (len) items.push_back(chr(plain_char()));
    end else begin
      items.push_back(chr(cur_quote));
      repeat (len) begin
        case ($urandom_range(0, 9))
          0: begin
            items.push_back(chr(cur_quote));
            items.push_back(chr(cur_quote));
          end
          1: items.push_back(chr(cur_delim));
          2: items.push_back(chr(CH_LF));
          default: items.push_back(chr(plain_char()));
        endcase
      end
      items.push_back(chr(cur_quote));
      // stray text after the closing quote
      if ($urandom_range(0, 7) == 0) items.push_back(chr(plain_char()));
    end
  endfunction

  function automatic void add_table(ref char_item_t items[$]);
    int unsigned n_rows, n_cols;
    n_rows = $urandom_range(1, 4);
    for (int r = 0; r < n_rows; r++) begin
      n_cols = $urandom_range(1, 5);
      for (int c = 0; c < n_cols; c++) begin
        add_field(items);
        if (c != n_cols - 1) begin
          items.push_back(chr(cur_delim));
          if ($urandom_range(0, 5) == 0) items.push_back(chr(cur_delim));
        end
      end
      if ($urandom_range(0, 3) == 0) items.push_back(chr(CH_CR));
      items.push_back(chr(CH_LF));
    end
    if ($urandom_range(0, 1) == 0) begin
      add_field(items);
      items.push_back(end_item());
    end
  endfunction

  function automatic void add_noise(ref char_item_t items[$]);
    int unsigned len;
    len = $urandom_range(3, 25);
    repeat (len) begin
      if ($urandom_range(0, 14) == 0) items.push_back(end_item());
      else items.push_back(chr(any_char()));
    end
  endfunction

  task automatic send_item(char_item_t it);
    in_valid     <= 1'b1;
    in_kind      <= it.kind;
    in_char_code <= it.code;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_list(ref char_item_t items[$], input int unsigned gap_odds);
    foreach (items[i]) begin
      send_item(items[i]);
      if (!calm && gap_odds != 0 && $urandom_range(1, 4 * gap_odds) == 1) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_config(logic [15:0] delim, logic [15:0] quote, logic ign,
                            logic [15:0] start);
    cur_delim = delim;
    cur_quote = quote;
    write_cfg(CFG_DELIMITER, delim);
    write_cfg(CFG_QUOTE, quote);
    write_cfg(CFG_IGNORE_DUP, {15'd0, ign});
    write_cfg(CFG_START_LINE, start);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(int unsigned budget, bit want_hold);
    char_item_t  items[$];
    int unsigned sent;
    sent = 0;
    while (sent < budget) begin
      items.delete();
      if ($urandom_range(0, 3) != 0) add_table(items);
      else add_noise(items);
      if (want_hold && sent >= budget / 3) begin
        hold_request = 1'b1;
        want_hold = 1'b0;
      end
      send_list(items, $urandom_range(0, 3));
      sent += items.size();
    end
    items.delete();
    items.push_back(end_item());
    send_list(items, 0);
  endtask

  initial begin : stimulus
    char_item_t  items[$];
    logic [16:0] directed[25];
    directed = '{17'd97, 17'd34, 17'd120, 17'd34, 17'd34, 17'd121, 17'd34, 17'd122,
                 17'd44, 17'd44, 17'd13, 17'd10, 17'd13, 17'd13, 17'd10, 17'hFFFF,
                 17'd0, 17'h10000, 17'h10000, 17'd34, 17'd44, 17'd10, 17'd34, 17'd10,
                 17'h1FFFF};
    tracker = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) items.push_back(char_item_t'(directed[i]));
    send_list(items, 2);
    settle();

    set_config(16'd44, 16'd34, 1'b0, 16'd0);
    run_random(140, 1'b1);
    settle();
    set_config(16'd59, 16'd39, 1'b1, 16'd2);
    run_random(100, 1'b0);
    settle();
    // no quoting
    set_config(16'hFFFF, 16'd0, 1'b1, 16'd0);
    run_random(80, 1'b0);
    settle();
    // every row hidden
    set_config(16'd0, 16'hFFFF, 1'b0, 16'hFFFF);
    run_random(50, 1'b0);
    settle();
    // newline as delimiter, carriage return as quote
    set_config(CH_LF, CH_CR, 1'b0, 16'd1);
    run_random(50, 1'b0);
    settle();
    // quote equal to delimiter
    set_config(16'd124, 16'd124, 1'b1, 16'd0);
    run_random(50, 1'b0);
    settle();

    // column counter saturation
    set_config(16'd44, 16'd34, 1'b0, 16'd0);
    items.delete();
    items.push_back(chr(16'd120));
    repeat (1030) items.push_back(chr(16'd44));
    items.push_back(chr(16'd121));
    items.push_back(chr(CH_LF));
    items.push_back(end_item());
    send_list(items, 0);
    settle();

    // no idling from here on
    calm = 1'b1;
    set_config(16'd44, 16'd34, 1'b0, 16'd1);
    run_random(50, 1'b0);
    settle();

    if (tracker.mismatches == 0) begin
      $display("PASS csv_field_tokenizer_core");
    end else begin
      $display("FAIL csv_field_tokenizer_core");
    end
    $finish;
  end

endmodule
